@@ sv/evr_pkg.sv @@
// shared types, constants and helper functions of the euler vector rotation block
package evr_pkg;

    localparam int DATA_BITS  = 32;
    localparam int INT_BITS   = DATA_BITS + 3;   // headroom between rotations
    localparam int TRIG_BITS  = 32;              // sine and cosine, q2.30
    localparam int TRIG_FRAC  = 30;
    localparam int PROD_BITS  = INT_BITS + TRIG_BITS;
    localparam int ANGLE_BITS = 31;
    localparam int TOL_BITS   = 21;
    localparam int IDX_BITS   = 3;
    localparam int CX_BITS    = 34;              // cordic x and y
    localparam int CZ_BITS    = 35;              // cordic angle accumulator
    localparam int STEPS      = 30;
    localparam int STEP_BITS  = 5;

    localparam logic signed [CX_BITS-1:0] GAIN_INV = CX_BITS'(652032874);
    localparam logic signed [CZ_BITS-1:0] PI_Q30 = CZ_BITS'(64'd3373259426);
    localparam logic signed [CZ_BITS-1:0] HALF_PI_Q30 = CZ_BITS'(64'd1686629713);

    localparam logic [IDX_BITS-1:0] REG_FIRST_ANGLE  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SECOND_ANGLE = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_THIRD_ANGLE  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FIRST_AXIS   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SECOND_AXIS  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_THIRD_AXIS   = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_TOLERANCE    = 3'd6;

    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_BAD = 2'd3
    } axis_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] in_x;
        logic signed [DATA_BITS-1:0] in_y;
        logic signed [DATA_BITS-1:0] in_z;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] out_x;
        logic signed [DATA_BITS-1:0] out_y;
        logic signed [DATA_BITS-1:0] out_z;
        logic                        status;
    } out_word_t;

    // vector travelling down the row of cells
    typedef struct packed {
        logic signed [INT_BITS-1:0] x;
        logic signed [INT_BITS-1:0] y;
        logic signed [INT_BITS-1:0] z;
        logic                       err;
    } vec_t;

    // per-cell rotation setup
    typedef struct packed {
        axis_t                       axis;
        logic                        skip;
        logic signed [TRIG_BITS-1:0] sin_v;
        logic signed [TRIG_BITS-1:0] cos_v;
    } cell_cfg_t;

    function automatic logic signed [CZ_BITS-1:0] atan_q30(input logic [STEP_BITS-1:0] i);
        logic signed [CZ_BITS-1:0] r;
        unique case (i)
            5'd0:    r = CZ_BITS'(843314856);
            5'd1:    r = CZ_BITS'(497837829);
            5'd2:    r = CZ_BITS'(263043836);
            5'd3:    r = CZ_BITS'(133525158);
            5'd4:    r = CZ_BITS'(67021686);
            5'd5:    r = CZ_BITS'(33543515);
            5'd6:    r = CZ_BITS'(16775850);
            5'd7:    r = CZ_BITS'(8388437);
            5'd8:    r = CZ_BITS'(4194282);
            5'd9:    r = CZ_BITS'(2097149);
            default: r = (CZ_BITS'(1) <<< (5'd30 - i)) - CZ_BITS'(1);
        endcase
        return r;
    endfunction

    // round(a * t / 2^30)
    function automatic logic signed [INT_BITS-1:0] mul_rnd(
        input logic signed [INT_BITS-1:0]  a,
        input logic signed [TRIG_BITS-1:0] t
    );
        logic signed [PROD_BITS-1:0] p;
        p = PROD_BITS'(a) * PROD_BITS'(t);
        p = p + (PROD_BITS'(1) <<< (TRIG_FRAC - 1));
        return p[TRIG_FRAC+INT_BITS-1:TRIG_FRAC];
    endfunction

endpackage

@@ sv/euler_three_axis_vector_rotation.sv @@
// top level: three rotation cells in a row, cordic sine and cosine unit, output register
//
//  channel   direction  handshake            payload
//  in        into       in_valid/in_ready    in_word  (in_x, in_y, in_z)
//  out       out of     out_valid/out_ready  out_word (out_x, out_y, out_z, status)
//  config    into       wr_en                wr_index, wr_data
//
// one word per cycle except during out stalls and cordic runs; two stages per cell, one output
// after reset the cordic unit computes all three sines and cosines, in_ready low meanwhile
// each angle write queues a cordic run: one start step then 30 iterations, in_ready low meanwhile
// a stall on out holds the whole row of cells in place
module euler_three_axis_vector_rotation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  evr_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output evr_pkg::out_word_t                  out_word,
    input  logic                                wr_en,
    input  logic [evr_pkg::IDX_BITS-1:0]        wr_index,
    input  logic [evr_pkg::ANGLE_BITS-1:0]      wr_data
);

    // configuration registers
    logic signed [evr_pkg::ANGLE_BITS-1:0] angle_reg [3];
    evr_pkg::axis_t                        axis_reg  [3];
    logic [evr_pkg::TOL_BITS-1:0]          tol_reg;
    logic signed [evr_pkg::TRIG_BITS-1:0]  sin_reg   [3];
    logic signed [evr_pkg::TRIG_BITS-1:0]  cos_reg   [3];

    // sine and cosine refresh bookkeeping
    logic [2:0] dirty_reg, dirty_next;
    logic [1:0] slot_reg, slot_next, pick;
    logic       start, cor_busy, cor_done, trig_busy;
    logic signed [evr_pkg::TRIG_BITS-1:0] cor_sin, cor_cos;

    // datapath
    logic                adv;
    logic                cv   [4];
    evr_pkg::vec_t       cvec [4];
    evr_pkg::cell_cfg_t  ccfg [3];
    logic                out_valid_reg;
    evr_pkg::out_word_t  out_word_reg, out_word_next;

    // pick the lowest angle that needs its sine and cosine refreshed
    always_comb
    begin
        priority if (dirty_reg[0])
            pick = 2'd0;
        else if (dirty_reg[1])
            pick = 2'd1;
        else
            pick = 2'd2;
        start     = !cor_busy && (dirty_reg != 3'b000);
        slot_next = start ? pick : slot_reg;
        dirty_next = dirty_reg;
        if (start)
            dirty_next[pick] = 1'b0;
        // a new write wins over the clear so a changed angle is rerun
        if (wr_en && wr_index <= evr_pkg::REG_THIRD_ANGLE)
            dirty_next[wr_index[1:0]] = 1'b1;
    end

    assign trig_busy = cor_busy || (dirty_reg != 3'b000);

    evr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .angle (angle_reg[pick]),
        .busy  (cor_busy),
        .done  (cor_done),
        .sin_v (cor_sin),
        .cos_v (cor_cos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg    <= 3'b111;
            slot_reg     <= 2'd0;
            angle_reg[0] <= '0;
            angle_reg[1] <= '0;
            angle_reg[2] <= '0;
            axis_reg[0]  <= evr_pkg::AXIS_Z;
            axis_reg[1]  <= evr_pkg::AXIS_X;
            axis_reg[2]  <= evr_pkg::AXIS_Z;
            tol_reg      <= evr_pkg::TOL_BITS'(268);
        end
        else
        begin
            dirty_reg <= dirty_next;
            slot_reg  <= slot_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    evr_pkg::REG_FIRST_ANGLE:  angle_reg[0] <= wr_data;
                    evr_pkg::REG_SECOND_ANGLE: angle_reg[1] <= wr_data;
                    evr_pkg::REG_THIRD_ANGLE:  angle_reg[2] <= wr_data;
                    evr_pkg::REG_FIRST_AXIS:   axis_reg[0] <= evr_pkg::axis_t'(wr_data[1:0]);
                    evr_pkg::REG_SECOND_AXIS:  axis_reg[1] <= evr_pkg::axis_t'(wr_data[1:0]);
                    evr_pkg::REG_THIRD_AXIS:   axis_reg[2] <= evr_pkg::axis_t'(wr_data[1:0]);
                    evr_pkg::REG_TOLERANCE:    tol_reg <= wr_data[evr_pkg::TOL_BITS-1:0];
                    default: ;   // writes past the register list are dropped
                endcase
            end
        end
    end

    // cordic result lands in the slot it was started for
    always_ff @(posedge clk)
    begin
        if (cor_done)
        begin
            sin_reg[slot_reg] <= cor_sin;
            cos_reg[slot_reg] <= cor_cos;
        end
    end

    // per-cell setup: skip when |angle| is within the tolerance
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [evr_pkg::ANGLE_BITS:0] mag;
            mag = angle_reg[k][evr_pkg::ANGLE_BITS-1]
                ? -{angle_reg[k][evr_pkg::ANGLE_BITS-1], angle_reg[k]}
                :  {1'b0, angle_reg[k]};
            ccfg[k].axis  = axis_reg[k];
            ccfg[k].skip  = mag <= (evr_pkg::ANGLE_BITS+1)'(tol_reg);
            ccfg[k].sin_v = sin_reg[k];
            ccfg[k].cos_v = cos_reg[k];
        end
    end

    // the whole row moves when the output register can take a word
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !trig_busy;

    always_comb
    begin
        cv[0]       = in_valid && in_ready;
        cvec[0].x   = evr_pkg::INT_BITS'(in_word.in_x);
        cvec[0].y   = evr_pkg::INT_BITS'(in_word.in_y);
        cvec[0].z   = evr_pkg::INT_BITS'(in_word.in_z);
        cvec[0].err = 1'b0;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_cell
        evr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .cfg       (ccfg[g]),
            .in_valid  (cv[g]),
            .in_vec    (cvec[g]),
            .out_valid (cv[g+1]),
            .out_vec   (cvec[g+1])
        );
    end

    function automatic logic signed [evr_pkg::DATA_BITS-1:0] sat(
        input logic signed [evr_pkg::INT_BITS-1:0] v
    );
        logic signed [evr_pkg::INT_BITS-1:0] mx, mn;
        mx = (evr_pkg::INT_BITS'(1) <<< (evr_pkg::DATA_BITS - 1)) - evr_pkg::INT_BITS'(1);
        mn = -mx - evr_pkg::INT_BITS'(1);
        priority if (v > mx)
            return mx[evr_pkg::DATA_BITS-1:0];
        else if (v < mn)
            return mn[evr_pkg::DATA_BITS-1:0];
        else
            return v[evr_pkg::DATA_BITS-1:0];
    endfunction

    // invalid axis on an applied rotation zeroes the vector
    always_comb
    begin
        if (cvec[3].err)
        begin
            out_word_next.out_x  = '0;
            out_word_next.out_y  = '0;
            out_word_next.out_z  = '0;
            out_word_next.status = 1'b1;
        end
        else
        begin
            out_word_next.out_x  = sat(cvec[3].x);
            out_word_next.out_y  = sat(cvec[3].y);
            out_word_next.out_z  = sat(cvec[3].z);
            out_word_next.status = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cv[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    a_no_accept_during_trig: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !trig_busy)
        else $error("word accepted while sine and cosine are being refreshed");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status) |->
            (out_word.out_x == 0 && out_word.out_y == 0 && out_word.out_z == 0))
        else $error("error word carries a nonzero vector");

    a_angle_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_index == evr_pkg::REG_FIRST_ANGLE) |=> dirty_reg[0])
        else $error("first angle write did not schedule a cordic run");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (cor_busy && !start))
        else $error("cordic done outside a run");
`endif

endmodule

@@ sv/evr_cordic.sv @@
// iterative cordic unit producing sine and cosine of one angle
module evr_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [evr_pkg::ANGLE_BITS-1:0]  angle,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [evr_pkg::TRIG_BITS-1:0]   sin_v,
    output logic signed [evr_pkg::TRIG_BITS-1:0]   cos_v
);

    logic                                 busy_reg, busy_next;
    logic [evr_pkg::STEP_BITS-1:0]        step_reg, step_next;
    logic                                 neg_reg, neg_next;
    logic signed [evr_pkg::CX_BITS-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [evr_pkg::CZ_BITS-1:0]   z_reg, z_next;
    logic signed [evr_pkg::CZ_BITS-1:0]   z0;
    logic signed [evr_pkg::CX_BITS-1:0]   xs, ys, xo, yo;

    always_comb
    begin
        z0 = evr_pkg::CZ_BITS'(angle) <<< 2;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (busy_reg)
        begin
            if (!z_reg[evr_pkg::CZ_BITS-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - evr_pkg::atan_q30(step_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + evr_pkg::atan_q30(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == evr_pkg::STEP_BITS'(evr_pkg::STEPS - 1))
                busy_next = 1'b0;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = evr_pkg::GAIN_INV;
            y_next    = '0;
            priority if (z0 > evr_pkg::HALF_PI_Q30)
            begin
                z_next   = z0 - evr_pkg::PI_Q30;
                neg_next = 1'b1;
            end
            else if (z0 < -evr_pkg::HALF_PI_Q30)
            begin
                z_next   = z0 + evr_pkg::PI_Q30;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = z0;
                neg_next = 1'b0;
            end
        end
        xo    = neg_reg ? -x_next : x_next;
        yo    = neg_reg ? -y_next : y_next;
        cos_v = xo[evr_pkg::TRIG_BITS-1:0];
        sin_v = yo[evr_pkg::TRIG_BITS-1:0];
        done  = busy_reg && (step_reg == evr_pkg::STEP_BITS'(evr_pkg::STEPS - 1));
        busy  = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

endmodule

@@ sv/evr_cell.sv @@
// one rotation cell: product stage then sum and write-back stage
module evr_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  evr_pkg::cell_cfg_t  cfg,
    input  logic                in_valid,
    input  evr_pkg::vec_t       in_vec,
    output logic                out_valid,
    output evr_pkg::vec_t       out_vec
);

    logic signed [evr_pkg::INT_BITS-1:0] a_in, b_in;
    logic signed [evr_pkg::INT_BITS-1:0] pc_reg, qs_reg, ps_reg, qc_reg;
    logic signed [evr_pkg::INT_BITS-1:0] na, nb;
    evr_pkg::vec_t vec_a_reg, res_next, res_reg;
    logic va_reg, vb_reg;

    always_comb
    begin
        unique case (cfg.axis)
            evr_pkg::AXIS_Y:
            begin
                a_in = in_vec.z;
                b_in = in_vec.x;
            end
            evr_pkg::AXIS_Z:
            begin
                a_in = in_vec.x;
                b_in = in_vec.y;
            end
            default:
            begin
                a_in = in_vec.y;
                b_in = in_vec.z;
            end
        endcase
    end

    always_comb
    begin
        na = pc_reg - qs_reg;
        nb = ps_reg + qc_reg;
        res_next = vec_a_reg;
        if (!cfg.skip)
        begin
            unique case (cfg.axis)
                evr_pkg::AXIS_X:
                begin
                    res_next.y = na;
                    res_next.z = nb;
                end
                evr_pkg::AXIS_Y:
                begin
                    res_next.z = na;
                    res_next.x = nb;
                end
                evr_pkg::AXIS_Z:
                begin
                    res_next.x = na;
                    res_next.y = nb;
                end
                default: res_next.err = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_a_reg <= in_vec;
            pc_reg    <= evr_pkg::mul_rnd(a_in, cfg.cos_v);
            qs_reg    <= evr_pkg::mul_rnd(b_in, cfg.sin_v);
            ps_reg    <= evr_pkg::mul_rnd(a_in, cfg.sin_v);
            qc_reg    <= evr_pkg::mul_rnd(b_in, cfg.cos_v);
            res_reg   <= res_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_vec   = res_reg;

endmodule
